@@ rtl/core/lcdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_pkg
// shared types, command codes and helpers of the lcd command interface
// ----------------------------------------------------------------------------
package lcdc_pkg;

    localparam int VRAM_SIZE_DEF = 32768;

    localparam logic [7:0] CMD_IDLE    = 8'h00;
    localparam logic [7:0] CMD_SYSSET  = 8'h40;
    localparam logic [7:0] CMD_MWRITE  = 8'h42;
    localparam logic [7:0] CMD_MREAD   = 8'h43;
    localparam logic [7:0] CMD_SCROLL  = 8'h44;
    localparam logic [7:0] CMD_CSRW    = 8'h46;
    localparam logic [7:0] CMD_CSRR    = 8'h47;
    localparam logic [7:0] CMD_DIR_R   = 8'h4c;
    localparam logic [7:0] CMD_DIR_L   = 8'h4d;
    localparam logic [7:0] CMD_DIR_U   = 8'h4e;
    localparam logic [7:0] CMD_DIR_D   = 8'h4f;
    localparam logic [7:0] CMD_DISPOFF = 8'h58;
    localparam logic [7:0] CMD_DISPON  = 8'h59;
    localparam logic [7:0] CMD_HDOT    = 8'h5a;
    localparam logic [7:0] CMD_OVLAY   = 8'h5b;
    localparam logic [7:0] CMD_CGRAM   = 8'h5c;
    localparam logic [7:0] CMD_CSRFORM = 8'h5d;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_WR    = 2'd1,
        KIND_RD    = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] bus_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        display_on;
        logic        changed;
        logic [15:0] cursor_address;
        logic [1:0]  mix_mode;
    } t_out_item;

    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic        display_on;
        logic        changed;
        logic        is_read;
        logic [15:0] cursor;
        logic [1:0]  mix;
    } t_ctrl_stat;

    function automatic logic [15:0] set_half(input logic [15:0] r, input logic hi,
                                             input logic [7:0] v);
        logic [15:0] res;
        res = hi ? {v, r[7:0]} : {r[15:8], v};
        return res;
    endfunction

endpackage

@@ rtl/core/lcd_controller_command_interface.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_controller_command_interface
// host command/data port of a graphic lcd controller with display memory
// ----------------------------------------------------------------------------
// Input channel carries one host access (command write, data write, data read
// or flush of the changed flag); output channel returns one result per access
// with the read byte, display enable, changed flag, cursor and layer mix.
// The result of an input transfer shows on the output the cycle after
// acceptance and holds there until taken. Throughput is one item per cycle
// unless the output stalls; the display memory read port is read once per
// data read and its read register doubles as the output holding stage.
// While a result waits on a stalled receiver no new item is taken; an item is
// taken in the same cycle as the waiting result leaves.
// After reset the display memory is cleared one entry per cycle, through all
// VRAM_SIZE entries (32768 at the default); the input is not ready until the
// sweep has finished. All control registers reset to zero.
// ----------------------------------------------------------------------------
module lcd_controller_command_interface #(
    parameter int VRAM_SIZE = lcdc_pkg::VRAM_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcdc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcdc_pkg::t_out_item o_out_data
);
    import lcdc_pkg::*;

    localparam int AW = $clog2(VRAM_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(VRAM_SIZE - 1);
    localparam logic [15:0]   ADDR_MASK = 16'(VRAM_SIZE - 1);

    t_state      r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic        r_out_valid, n_out_valid;
    logic        accept;
    t_mem_req    mem_req;
    t_ctrl_stat  stat;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] acc_addr;
    logic [7:0]  ram_wdata;
    logic [7:0]  ram_rdata;

    assign o_in_ready = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign acc_addr   = AW'(mem_req.addr & ADDR_MASK);

    lcdc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_data),
        .o_mem_req (mem_req),
        .o_stat    (stat)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = acc_addr;
        ram_wdata   = mem_req.wdata;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_RUN;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_RUN: begin
                ram_we = mem_req.we;
                if (accept) begin
                    n_out_valid = 1'b1;
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    lcdc_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_SIZE)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (mem_req.re),
        .i_raddr (acc_addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = '{read_byte:      stat.is_read ? ram_rdata : 8'h00,
                           display_on:     stat.display_on,
                           changed:        stat.changed,
                           cursor_address: stat.cursor,
                           mix_mode:       stat.mix};

endmodule

@@ rtl/core/lcdc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lcdc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_ctrl
// command decoder, parameter registers and cursor of the lcd command interface
// ----------------------------------------------------------------------------
module lcdc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  lcdc_pkg::t_in_item   i_item,
    output lcdc_pkg::t_mem_req   o_mem_req,
    output lcdc_pkg::t_ctrl_stat o_stat
);
    import lcdc_pkg::*;

    logic [7:0]  r_mode,        n_mode;
    logic [3:0]  r_stage,       n_stage;
    logic [3:0]  r_left,        n_left;
    logic        r_disp,        n_disp;
    logic        r_dirty,       n_dirty;
    logic [5:0]  r_sys_flags,   n_sys_flags;
    logic [2:0]  r_char_w,      n_char_w;
    logic [4:0]  r_char_h,      n_char_h;
    logic [7:0]  r_line_bytes [3];
    logic [7:0]  n_line_bytes [3];
    logic [15:0] r_pitch,       n_pitch;
    logic [15:0] r_blk_start [4];
    logic [15:0] n_blk_start [4];
    logic [7:0]  r_blk_lines [2];
    logic [7:0]  n_blk_lines [2];
    logic [2:0]  r_hdot,        n_hdot;
    logic [4:0]  r_ovl,         n_ovl;
    logic [15:0] r_font_base,   n_font_base;
    logic [1:0]  r_dir,         n_dir;
    logic [15:0] r_cursor,      n_cursor;
    logic        r_changed,     n_changed;
    logic        r_is_read,     n_is_read;

    logic        adv;
    logic [7:0]  v;
    logic [3:0]  s;

    assign v = i_item.bus_byte;
    assign s = r_stage;

    always_comb begin
        n_mode       = r_mode;
        n_stage      = r_stage;
        n_left       = r_left;
        n_disp       = r_disp;
        n_dirty      = r_dirty;
        n_sys_flags  = r_sys_flags;
        n_char_w     = r_char_w;
        n_char_h     = r_char_h;
        n_line_bytes = r_line_bytes;
        n_pitch      = r_pitch;
        n_blk_start  = r_blk_start;
        n_blk_lines  = r_blk_lines;
        n_hdot       = r_hdot;
        n_ovl        = r_ovl;
        n_font_base  = r_font_base;
        n_dir        = r_dir;
        n_cursor     = r_cursor;
        n_changed    = r_changed;
        n_is_read    = r_is_read;
        adv          = 1'b0;
        o_mem_req    = '{we: 1'b0, re: 1'b0, addr: r_cursor, wdata: v};

        if (i_accept) begin
            n_changed = 1'b0;
            n_is_read = 1'b0;
            unique case (i_item.kind)
                KIND_CMD: begin
                    unique case (v)
                        CMD_SYSSET: begin
                            n_disp  = 1'b0;
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd8;
                        end
                        CMD_MWRITE, CMD_MREAD: begin
                            n_mode = v;
                            n_left = '0;
                        end
                        CMD_SCROLL: begin
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd10;
                        end
                        CMD_CSRW, CMD_CSRR, CMD_CGRAM, CMD_CSRFORM: begin
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd2;
                        end
                        CMD_DIR_R, CMD_DIR_L, CMD_DIR_U, CMD_DIR_D: begin
                            n_dir  = v[1:0];
                            n_mode = CMD_IDLE;
                        end
                        CMD_DISPOFF: begin
                            n_disp  = 1'b0;
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd1;
                        end
                        CMD_DISPON: begin
                            n_disp  = 1'b1;
                            n_dirty = 1'b1;
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd1;
                        end
                        CMD_HDOT, CMD_OVLAY: begin
                            n_mode  = v;
                            n_stage = '0;
                            n_left  = 4'd1;
                        end
                        default: begin
                            n_mode = CMD_IDLE;
                        end
                    endcase
                end
                KIND_WR: begin
                    unique case (r_mode)
                        CMD_SYSSET: begin
                            adv = 1'b1;
                            unique case (s)
                                4'd0: n_sys_flags = {r_sys_flags[5], v[5], v[3:0]};
                                4'd1: begin
                                    n_char_w    = v[2:0];
                                    n_sys_flags = {v[7], r_sys_flags[4:0]};
                                end
                                4'd2: n_char_h = {1'b0, v[3:0]};
                                4'd3: n_line_bytes[0] = v;
                                4'd4: n_line_bytes[1] = v;
                                4'd5: n_line_bytes[2] = v;
                                4'd6, 4'd7: n_pitch = set_half(r_pitch, s[0], v);
                                default: ;
                            endcase
                        end
                        CMD_SCROLL: begin
                            adv = 1'b1;
                            unique case (s)
                                4'd0, 4'd1:
                                    n_blk_start[0] = set_half(r_blk_start[0], s[0], v);
                                4'd2: n_blk_lines[0] = v;
                                4'd3: n_blk_start[1] = set_half(r_blk_start[1], 1'b0, v);
                                4'd4: n_blk_start[1] = set_half(r_blk_start[1], 1'b1, v);
                                4'd5: n_blk_lines[1] = v;
                                4'd6, 4'd7:
                                    n_blk_start[2] = set_half(r_blk_start[2], s[0], v);
                                4'd8, 4'd9:
                                    n_blk_start[3] = set_half(r_blk_start[3], s[0], v);
                                default: ;
                            endcase
                        end
                        CMD_CSRW: begin
                            adv      = 1'b1;
                            n_cursor = set_half(r_cursor, s != '0, v);
                        end
                        CMD_MWRITE: begin
                            o_mem_req.we = 1'b1;
                            n_cursor     = r_cursor + 16'd1;
                            n_dirty      = 1'b1;
                        end
                        CMD_HDOT: begin
                            adv    = 1'b1;
                            n_hdot = v[2:0];
                        end
                        CMD_OVLAY: begin
                            adv   = 1'b1;
                            n_ovl = v[4:0];
                        end
                        CMD_CGRAM: begin
                            adv         = 1'b1;
                            n_font_base = set_half(r_font_base, s != '0, v);
                        end
                        CMD_DISPOFF, CMD_DISPON, CMD_CSRFORM: begin
                            adv = 1'b1;
                        end
                        default: ;
                    endcase
                    if (adv) begin
                        n_stage = r_stage + 4'd1;
                        if (r_left != '0) begin
                            n_left = r_left - 4'd1;
                            if (r_left == 4'd1) begin
                                n_mode = CMD_IDLE;
                            end
                        end
                    end
                end
                KIND_RD: begin
                    o_mem_req.re = 1'b1;
                    n_is_read    = 1'b1;
                    if (r_mode == CMD_MREAD) begin
                        n_cursor = r_cursor + 16'd1;
                    end
                end
                KIND_FLUSH: begin
                    n_changed = r_dirty;
                    n_dirty   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= CMD_IDLE;
            r_stage      <= '0;
            r_left       <= '0;
            r_disp       <= 1'b0;
            r_dirty      <= 1'b0;
            r_sys_flags  <= '0;
            r_char_w     <= '0;
            r_char_h     <= '0;
            r_line_bytes <= '{default: '0};
            r_pitch      <= '0;
            r_blk_start  <= '{default: '0};
            r_blk_lines  <= '{default: '0};
            r_hdot       <= '0;
            r_ovl        <= '0;
            r_font_base  <= '0;
            r_dir        <= '0;
            r_cursor     <= '0;
            r_changed    <= 1'b0;
            r_is_read    <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_stage      <= n_stage;
            r_left       <= n_left;
            r_disp       <= n_disp;
            r_dirty      <= n_dirty;
            r_sys_flags  <= n_sys_flags;
            r_char_w     <= n_char_w;
            r_char_h     <= n_char_h;
            r_line_bytes <= n_line_bytes;
            r_pitch      <= n_pitch;
            r_blk_start  <= n_blk_start;
            r_blk_lines  <= n_blk_lines;
            r_hdot       <= n_hdot;
            r_ovl        <= n_ovl;
            r_font_base  <= n_font_base;
            r_dir        <= n_dir;
            r_cursor     <= n_cursor;
            r_changed    <= n_changed;
            r_is_read    <= n_is_read;
        end
    end

    assign o_stat = '{display_on: r_disp, changed: r_changed, is_read: r_is_read,
                      cursor: r_cursor, mix: r_ovl[1:0]};

endmodule

@@ rtl/core/lcdc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_chk
// port-level checks of the lcd command interface, bound to the top level
// ----------------------------------------------------------------------------
module lcdc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lcdc_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lcdc_pkg::t_out_item o_out_data
);
    import lcdc_pkg::*;

    // memory sweep follows every reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // every input transfer yields a result the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no result after input transfer");

    // no new item while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input ready while output stalled");

    // changed flag only reported for a flush
    a_changed_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.kind != KIND_FLUSH))
            |=> !o_out_data.changed)
        else $error("changed set on non-flush item");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output changed while stalled");

endmodule

bind lcd_controller_command_interface lcdc_chk u_lcdc_chk (.*);
